// ===== sv/cooked_tty_line_discipline_assert.svh =====
// Assertion macros used by the checker of the line discipline.
`ifndef COOKED_TTY_LINE_DISCIPLINE_ASSERT_SVH
`define COOKED_TTY_LINE_DISCIPLINE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define CTLD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line discipline check failed");

// The consequent must hold in the same cycle as the antecedent.
`define CTLD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line discipline check failed");

`endif

// ===== sv/ctld_pkg.sv =====
package ctld_pkg;

    localparam int LINE_MAX   = 32;
    localparam int IDX_W      = $clog2(LINE_MAX);
    localparam int LEN_W      = $clog2(LINE_MAX + 1);
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 6;
    localparam int CMP_W      = 7;

    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

    localparam logic [CFG_DATA_W-1:0] READ_SIZE_RESET = 6'd32;

    typedef enum logic [1:0] {
        CFG_READ_SIZE,
        CFG_ECHO,
        CFG_IN_CRLF,
        CFG_OUT_CRLF
    } t_cfg_idx;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_EDIT,
        ST_STORE_LF,
        ST_EVAL,
        ST_ECHO_CR,
        ST_ECHO_CH,
        ST_LINE
    } t_step;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_EDIT,
        OP_STORE_LF,
        OP_EVAL,
        OP_ECHO_CR,
        OP_ECHO_CH,
        OP_LINE
    } t_op;

    typedef enum logic [1:0] {
        C_NEVER,
        C_DEL_EMPTY,
        C_NO_LINE,
        C_LINE_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    // Control store: one word per step, jump to jmp when cond holds, else go to nxt.
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            ST_FETCH:    w = '{OP_FETCH,    C_NEVER,     ST_FETCH, ST_EDIT};
            ST_EDIT:     w = '{OP_EDIT,     C_DEL_EMPTY, ST_FETCH, ST_STORE_LF};
            ST_STORE_LF: w = '{OP_STORE_LF, C_NEVER,     ST_FETCH, ST_EVAL};
            ST_EVAL:     w = '{OP_EVAL,     C_NEVER,     ST_FETCH, ST_ECHO_CR};
            ST_ECHO_CR:  w = '{OP_ECHO_CR,  C_NEVER,     ST_FETCH, ST_ECHO_CH};
            ST_ECHO_CH:  w = '{OP_ECHO_CH,  C_NO_LINE,   ST_FETCH, ST_LINE};
            ST_LINE:     w = '{OP_LINE,     C_LINE_MORE, ST_LINE,  ST_FETCH};
            default:     w = '{OP_FETCH,    C_NEVER,     ST_FETCH, ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/ctld_in_if.sv =====
interface ctld_in_if;
    logic                         valid;
    logic                         ready;
    logic [ctld_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/ctld_out_if.sv =====
interface ctld_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [ctld_pkg::BYTE_W-1:0]  out_byte;
    logic                         last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== sv/cooked_tty_line_discipline.sv =====
// Cooked-mode terminal line discipline.
// The i_rx channel carries one received keyboard byte per word. The o_res channel
// carries the words that byte causes: echo bytes (kind 0) first, then, when the
// line completes, every stored line byte (kind 1); last marks the final word of
// one input byte. A DEL on an empty line causes no word at all, and with echo
// off a byte that does not complete a line causes none either.
// Configuration must be written through i_cfg_we / i_cfg_idx / i_cfg_data only
// while idle, which the block itself does not enforce. Each input byte runs
// through six fixed program steps, the echo words going out during two of them;
// when the line completes, it is read out of the line store one byte per cycle
// while the receiver takes them. A DEL on an empty line ends after the fetch and
// edit steps. The sequencer takes one byte at a time; i_rx.ready is high only in
// its fetch step. The first word follows the EDIT, STORE_LF and EVAL steps.
// Reset (synchronous, active low) empties the line, restores the registers to
// read size 32 with echo, CR LF storage and CR LF echo on, and clears o_res.valid.
// The line store itself is not cleared; only written entries are ever delivered.
// When the receiver stalls, the word waits in the output register and the
// program stops at any step with a word to send until the register frees up;
// an input byte is still taken while the final word of the previous one waits.
module cooked_tty_line_discipline (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ctld_in_if.sink                            i_rx,
    ctld_out_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  ctld_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [ctld_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ctld_pkg::*;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_read_size;
    logic                  r_echo;
    logic                  r_in_crlf;
    logic                  r_out_crlf;

    // Sequencer and datapath state.
    t_step             r_step, n_step;
    logic [BYTE_W-1:0] r_ch, n_ch;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_dlv, n_dlv;
    logic [BYTE_W-1:0] r_mem [LINE_MAX];
    logic [BYTE_W-1:0] r_rdata;

    // Output register.
    logic              r_ovalid, n_ovalid;
    logic              r_okind;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;

    t_uword            w_uw;
    logic              w_done;
    logic              w_cond;
    logic              w_req;
    logic              w_go;
    logic              w_out_free;
    logic              w_kind;
    logic [BYTE_W-1:0] w_byte;
    logic              w_last;
    logic              w_wr_en;
    logic [BYTE_W-1:0] w_wr_data;
    logic [CMP_W-1:0]  w_size;
    logic [CMP_W-1:0]  w_len_x;
    logic              w_room;
    logic              w_is_del;
    logic              w_is_lf;
    logic              w_is_cr;
    logic              w_idx_last;

    // Effective read size: zero acts as one, anything above the line size is capped.
    always_comb begin
        if (r_read_size == '0) begin
            w_size = CMP_W'(1);
        end else if (CMP_W'(r_read_size) > CMP_W'(LINE_MAX)) begin
            w_size = CMP_W'(LINE_MAX);
        end else begin
            w_size = CMP_W'(r_read_size);
        end
    end

    assign w_len_x    = CMP_W'(r_len);
    assign w_room     = w_len_x < CMP_W'(LINE_MAX);
    assign w_is_del   = r_ch == CH_DEL;
    assign w_is_lf    = r_ch == CH_LF;
    assign w_is_cr    = r_ch == CH_CR;
    assign w_idx_last = (CMP_W'(r_idx) + CMP_W'(1)) == w_len_x;
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_go       = w_req && w_out_free;

    assign w_uw = ucode_rom(r_step);

    // Step control: jump decision and completion of the current step.
    always_comb begin
        case (w_uw.cond)
            C_NEVER:     w_cond = 1'b0;
            C_DEL_EMPTY: w_cond = w_is_del && (r_len == '0);
            C_NO_LINE:   w_cond = !r_dlv;
            C_LINE_MORE: w_cond = !w_idx_last;
            default:     w_cond = 1'b0;
        endcase

        case (w_uw.op)
            OP_FETCH:   w_done = i_rx.valid;
            OP_ECHO_CR,
            OP_ECHO_CH,
            OP_LINE:    w_done = !w_req || w_out_free;
            default:    w_done = 1'b1;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (w_done) begin
            n_step = w_cond ? w_uw.jmp : w_uw.nxt;
        end
    end

    // Datapath control decoded from the current control word.
    always_comb begin
        n_ch      = r_ch;
        n_len     = r_len;
        n_idx     = r_idx;
        n_dlv     = r_dlv;
        w_wr_en   = 1'b0;
        w_wr_data = r_ch;
        w_req     = 1'b0;
        w_kind    = 1'b0;
        w_byte    = r_ch;
        w_last    = 1'b0;
        i_rx.ready = 1'b0;

        case (w_uw.op)
            OP_FETCH: begin
                i_rx.ready = 1'b1;
                if (i_rx.valid) begin
                    n_ch = i_rx.rx_byte;
                end
            end
            OP_EDIT: begin
                if (w_is_del) begin
                    if (r_len != '0) begin
                        n_len = r_len - LEN_W'(1);
                    end
                end else if (w_is_lf) begin
                    // The CR goes in only when CR and LF both fit the read size.
                    if (r_in_crlf && (w_len_x + CMP_W'(1) < w_size) && w_room) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = CH_CR;
                        n_len     = r_len + LEN_W'(1);
                    end
                end else if (w_room) begin
                    w_wr_en = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                end
            end
            OP_STORE_LF: begin
                if (w_is_lf && w_room) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = CH_LF;
                    n_len     = r_len + LEN_W'(1);
                end
            end
            OP_EVAL: begin
                n_dlv = (w_is_cr || w_is_lf || (w_len_x >= w_size)) && (r_len != '0);
                n_idx = '0;
            end
            OP_ECHO_CR: begin
                w_req  = r_echo && w_is_lf && r_out_crlf;
                w_byte = CH_CR;
            end
            OP_ECHO_CH: begin
                w_req  = r_echo;
                w_last = !r_dlv;
            end
            OP_LINE: begin
                w_req  = 1'b1;
                w_kind = 1'b1;
                w_byte = r_rdata;
                w_last = w_idx_last;
                if (w_go) begin
                    n_idx = r_idx + IDX_W'(1);
                    if (w_idx_last) begin
                        n_len = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_go) begin
            n_ovalid = 1'b1;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_FETCH;
            r_len       <= '0;
            r_dlv       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_read_size <= READ_SIZE_RESET;
            r_echo      <= 1'b1;
            r_in_crlf   <= 1'b1;
            r_out_crlf  <= 1'b1;
        end else begin
            r_step   <= n_step;
            r_len    <= n_len;
            r_dlv    <= n_dlv;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_READ_SIZE: r_read_size <= i_cfg_data;
                    CFG_ECHO:      r_echo      <= i_cfg_data[0];
                    CFG_IN_CRLF:   r_in_crlf   <= i_cfg_data[0];
                    CFG_OUT_CRLF:  r_out_crlf  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers and the line store.
    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_idx <= n_idx;
        if (w_go) begin
            r_okind <= w_kind;
            r_obyte <= w_byte;
            r_olast <= w_last;
        end
        if (w_wr_en) begin
            r_mem[r_len[IDX_W-1:0]] <= w_wr_data;
        end
        // Reading at the next index keeps r_rdata equal to the entry at r_idx.
        r_rdata <= r_mem[n_idx];
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.kind     = r_okind;
    assign o_res.out_byte = r_obyte;
    assign o_res.last     = r_olast;

endmodule

// ===== sv/ctld_checker.sv =====
`include "cooked_tty_line_discipline_assert.svh"

module ctld_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rx_ready,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_res_kind,
    input  logic [ctld_pkg::BYTE_W-1:0]   i_res_byte,
    input  logic                          i_res_last
);

    logic                          w_stall;
    logic                          w_line_more;
    logic                          w_mid_item;
    logic [ctld_pkg::BYTE_W+1:0]   w_payload;

    assign w_stall     = i_res_valid && !i_res_ready;
    assign w_line_more = i_res_valid && i_res_ready && i_res_kind && !i_res_last;
    assign w_mid_item  = i_res_valid && !i_res_last;
    assign w_payload   = {i_res_kind, i_res_byte, i_res_last};

    `CTLD_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, w_stall, i_res_valid)
    `CTLD_ASSERT_NEXT(a_payload_held, i_clk, i_rst_n, w_stall, $stable(w_payload))
    // Line bytes stream back to back once the receiver takes them.
    `CTLD_ASSERT_NEXT(a_line_streams, i_clk, i_rst_n, w_line_more, i_res_valid && i_res_kind)
    // A new byte is taken only after the final word of the previous one is queued.
    `CTLD_ASSERT_SAME(a_no_fetch_mid_item, i_clk, i_rst_n, w_mid_item, !i_rx_ready)

endmodule

bind cooked_tty_line_discipline ctld_checker u_ctld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind),
    .i_res_byte  (o_res.out_byte),
    .i_res_last  (o_res.last)
);
